/* rtl/crd_pkg.sv */
package crd_pkg;

    // One beat of reference text.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        last;
    } t_in;

    // One decoded result, given on the last beat of a reference.
    typedef struct packed {
        logic        resolved;
        logic [1:0]  unit_count;
        logic [15:0] first_unit;
        logic [15:0] second_unit;
    } t_out;

    // Running state for the reference in progress.
    typedef struct packed {
        logic [3:0]  position;
        logic [5:0]  named_candidates;
        logic        prefix_good;
        logic        hex_form;
        logic [20:0] code_value;
        logic        value_overflow;
        logic        body_bad;
        logic        digit_seen;
    } t_state;

    localparam int NAME_COUNT = 6;

    localparam logic [15:0] CH_AMP    = 16'h0026;
    localparam logic [15:0] CH_HASH   = 16'h0023;
    localparam logic [15:0] CH_SEMI   = 16'h003B;
    localparam logic [15:0] CH_LOW_X  = 16'h0078;
    localparam logic [15:0] CH_HIGH_X = 16'h0058;

    localparam logic [20:0] CODE_MAX      = 21'h10FFFF;
    localparam logic [20:0] BMP_MAX       = 21'h00FFFF;
    localparam logic [20:0] SURR_LOW      = 21'h00D800;
    localparam logic [20:0] SURR_HIGH     = 21'h00DFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h010000;
    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
    localparam logic [9:0]  SURR_MASK      = 10'h3FF;

    // Name texts in the order amp, lt, gt, quot, apos, nbsp, padded to eight units.
    localparam logic [15:0] NAME_TEXT [NAME_COUNT][8] = '{
        '{16'h26, 16'h61, 16'h6D, 16'h70, 16'h3B, 16'h00, 16'h00, 16'h00},
        '{16'h26, 16'h6C, 16'h74, 16'h3B, 16'h00, 16'h00, 16'h00, 16'h00},
        '{16'h26, 16'h67, 16'h74, 16'h3B, 16'h00, 16'h00, 16'h00, 16'h00},
        '{16'h26, 16'h71, 16'h75, 16'h6F, 16'h74, 16'h3B, 16'h00, 16'h00},
        '{16'h26, 16'h61, 16'h70, 16'h6F, 16'h73, 16'h3B, 16'h00, 16'h00},
        '{16'h26, 16'h6E, 16'h62, 16'h73, 16'h70, 16'h3B, 16'h00, 16'h00}
    };
    localparam logic [3:0]  NAME_LEN [NAME_COUNT] = '{4'd5, 4'd4, 4'd4, 4'd6, 4'd6, 4'd6};
    localparam logic [15:0] NAME_VALUE [NAME_COUNT] = '{
        16'h0026, 16'h003C, 16'h003E, 16'h0022, 16'h0027, 16'h0020
    };

    localparam t_state STATE_RESET = '{
        position:         4'd0,
        named_candidates: 6'h3F,
        prefix_good:      1'b1,
        hex_form:         1'b0,
        code_value:       21'd0,
        value_overflow:   1'b0,
        body_bad:         1'b0,
        digit_seen:       1'b0
    };

endpackage

/* rtl/crd_step.sv */
module crd_step (
    input  crd_pkg::t_state i_state,
    input  crd_pkg::t_in    i_beat,
    output crd_pkg::t_state o_state,
    output crd_pkg::t_out   o_result
);

    // Digit value 0..15, or 16 when the unit is no hex digit.
    function automatic logic [4:0] digit_of(input logic [15:0] u);
        logic [4:0] d;
        d = 5'd16;
        if (u >= 16'h30 && u <= 16'h39) begin
            d = 5'(u - 16'h30);
        end else if (u >= 16'h61 && u <= 16'h66) begin
            d = 5'(u - 16'h61 + 16'd10);
        end else if (u >= 16'h41 && u <= 16'h46) begin
            d = 5'(u - 16'h41 + 16'd10);
        end
        return d;
    endfunction

    logic [15:0] u;
    logic [3:0]  pos;
    logic [4:0]  digit;
    logic        digit_ok;
    logic [24:0] cv_wide;
    logic [24:0] nv;
    logic [20:0] adj;
    logic        named_hit;

    assign u   = i_beat.code_unit;
    assign pos = i_state.position;

    always_comb begin
        digit    = digit_of(u);
        digit_ok = i_state.hex_form ? (digit < 5'd16) : (digit < 5'd10);
        cv_wide  = {4'd0, i_state.code_value};
        if (i_state.hex_form) begin
            nv = (cv_wide << 4) + {20'd0, digit};
        end else begin
            nv = (cv_wide << 3) + (cv_wide << 1) + {20'd0, digit};
        end
        adj = i_state.code_value - crd_pkg::SUPP_BASE;
    end

    always_comb begin
        o_state   = i_state;
        o_result  = '0;
        named_hit = 1'b0;

        for (int k = 0; k < crd_pkg::NAME_COUNT; k++) begin
            if (!(pos < crd_pkg::NAME_LEN[k] && crd_pkg::NAME_TEXT[k][pos[2:0]] == u)) begin
                o_state.named_candidates[k] = 1'b0;
            end
        end

        if (pos == 4'd0 && u != crd_pkg::CH_AMP) begin
            o_state.prefix_good = 1'b0;
        end
        if (pos == 4'd1 && u != crd_pkg::CH_HASH) begin
            o_state.prefix_good = 1'b0;
        end

        if (!i_beat.last) begin
            if (pos == 4'd2 && (u == crd_pkg::CH_LOW_X || u == crd_pkg::CH_HIGH_X)) begin
                o_state.hex_form = 1'b1;
            end else if (pos >= 4'd2) begin
                if (!digit_ok) begin
                    o_state.body_bad = 1'b1;
                end else begin
                    o_state.digit_seen = 1'b1;
                    if (!i_state.value_overflow) begin
                        if (nv > {4'd0, crd_pkg::CODE_MAX}) begin
                            o_state.value_overflow = 1'b1;
                        end else begin
                            o_state.code_value = nv[20:0];
                        end
                    end
                end
            end
            if (pos != 4'd15) begin
                o_state.position = pos + 4'd1;
            end
        end else begin
            // The first surviving name in list order wins.
            for (int k = 0; k < crd_pkg::NAME_COUNT; k++) begin
                if (!named_hit && o_state.named_candidates[k]
                        && 5'(pos) + 5'd1 == 5'(crd_pkg::NAME_LEN[k])) begin
                    named_hit           = 1'b1;
                    o_result.resolved   = 1'b1;
                    o_result.unit_count = 2'd1;
                    o_result.first_unit = crd_pkg::NAME_VALUE[k];
                end
            end

            if (!named_hit && o_state.prefix_good && pos >= 4'd3 && u == crd_pkg::CH_SEMI
                    && i_state.digit_seen && !i_state.body_bad && !i_state.value_overflow
                    && i_state.code_value != 21'd0) begin
                if (i_state.code_value <= crd_pkg::BMP_MAX) begin
                    if (i_state.code_value < crd_pkg::SURR_LOW
                            || i_state.code_value > crd_pkg::SURR_HIGH) begin
                        o_result.resolved   = 1'b1;
                        o_result.unit_count = 2'd1;
                        o_result.first_unit = i_state.code_value[15:0];
                    end
                end else begin
                    o_result.resolved    = 1'b1;
                    o_result.unit_count  = 2'd2;
                    o_result.first_unit  = crd_pkg::HIGH_SURR_BASE + {6'd0, adj[19:10]};
                    o_result.second_unit = crd_pkg::LOW_SURR_BASE
                                           + {6'd0, adj[9:0] & crd_pkg::SURR_MASK};
                end
            end

            o_state = crd_pkg::STATE_RESET;
        end
    end

endmodule

/* rtl/char_reference_decoder.sv */
// Decodes one HTML character reference per run of beats: each input beat carries one
// UTF-16 unit, starting at the ampersand, and the beat with last set closes the reference
// and yields exactly one result beat (non-last beats yield none). The six names amp, lt,
// gt, quot, apos and nbsp (mapped to a space) and the forms &#N; and &#xH; are decoded;
// anything else gives resolved = 0 with no units. The block takes one beat every cycle:
// each beat is registered, the running state is updated in one pass of logic, and a
// result enters the output register when its last beat leaves the input register. Input
// stalls only when a last beat is waiting while the output register still holds a
// result that the consumer is stalling.
module char_reference_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  crd_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output crd_pkg::t_out  o_out
);

    logic            r_in_valid;
    crd_pkg::t_in    r_in;
    crd_pkg::t_state r_state;
    logic            r_out_valid;
    crd_pkg::t_out   r_out;

    crd_pkg::t_state n_state;
    crd_pkg::t_out   n_out;
    logic            advance;
    logic            in_accept;

    crd_step u_step (
        .i_state  (r_state),
        .i_beat   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // A non-last beat never needs the output register, so it always moves on.
    assign advance    = r_in_valid && (!r_in.last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crd_pkg::STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.last |=> r_out_valid)
        else $error("last beat did not produce a result");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.last |=> r_state == crd_pkg::STATE_RESET)
        else $error("state not cleared after a reference");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_in.last && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    a_result_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.resolved == (r_out.unit_count != 2'd0))
                        && r_out.unit_count != 2'd3
                        && (r_out.unit_count == 2'd2 || r_out.second_unit == 16'd0))
        else $error("inconsistent result fields");

endmodule
